FILE: sv/segi_pkg.sv
// Shared constants for the segment intersection core.
// No dependencies; compile first.
`default_nettype none
package segi_pkg;
   localparam int COORD_BITS_DEF = 16;   // default coordinate width
   localparam int FRAC_BITS_DEF  = 8;    // default fraction bits of the point
   localparam int OUT_BITS       = 24;   // width of point_x and point_y
endpackage
`default_nettype wire

FILE: sv/segi_if.sv
// Valid/ready channel interfaces: request (two segments) and response (hit point).
// Depends on segi_pkg.
`default_nettype none
interface segi_req_if #(parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] wall_ax;
   logic signed [COORD_BITS-1:0] wall_ay;
   logic signed [COORD_BITS-1:0] wall_bx;
   logic signed [COORD_BITS-1:0] wall_by;
   logic signed [COORD_BITS-1:0] ray_start_x;
   logic signed [COORD_BITS-1:0] ray_start_y;
   logic signed [COORD_BITS-1:0] ray_end_x;
   logic signed [COORD_BITS-1:0] ray_end_y;
   modport source (output valid, wall_ax, wall_ay, wall_bx, wall_by,
                   ray_start_x, ray_start_y, ray_end_x, ray_end_y, input ready);
   modport sink   (input valid, wall_ax, wall_ay, wall_bx, wall_by,
                   ray_start_x, ray_start_y, ray_end_x, ray_end_y, output ready);
endinterface

interface segi_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 hit;
   logic signed [segi_pkg::OUT_BITS-1:0] point_x;
   logic signed [segi_pkg::OUT_BITS-1:0] point_y;
   modport source (output valid, hit, point_x, point_y, input ready);
   modport sink   (input valid, hit, point_x, point_y, output ready);
endinterface
`default_nettype wire

FILE: sv/segi_cross.sv
// Front end: direction vectors, cross products, sign-normalised den/tn/sn.
// Three register stages; depends on segi_pkg for the default width.
`default_nettype none
module segi_cross #(
   parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic signed [COORD_BITS-1:0]   ax,
   input  wire logic signed [COORD_BITS-1:0]   ay,
   input  wire logic signed [COORD_BITS-1:0]   bx,
   input  wire logic signed [COORD_BITS-1:0]   by,
   input  wire logic signed [COORD_BITS-1:0]   sx,
   input  wire logic signed [COORD_BITS-1:0]   sy,
   input  wire logic signed [COORD_BITS-1:0]   ex,
   input  wire logic signed [COORD_BITS-1:0]   ey,
   output logic signed [2*COORD_BITS+2:0]      den,
   output logic signed [2*COORD_BITS+2:0]      tn,
   output logic signed [2*COORD_BITS+2:0]      sn,
   output logic signed [COORD_BITS-1:0]        ax_out,
   output logic signed [COORD_BITS-1:0]        ay_out,
   output logic signed [COORD_BITS:0]          d1x_out,
   output logic signed [COORD_BITS:0]          d1y_out
);
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;
   localparam int XW = 2 * COORD_BITS + 3;

   // stage 1: differences
   logic signed [DW-1:0]         d1x_ff, d1y_ff, d2x_ff, d2y_ff, cx_ff, cy_ff;
   logic signed [COORD_BITS-1:0] ax1_ff, ay1_ff;
   // stage 2: products
   logic signed [PW-1:0]         p_den_a_ff, p_den_b_ff, p_tn_a_ff, p_tn_b_ff;
   logic signed [PW-1:0]         p_sn_a_ff, p_sn_b_ff;
   logic signed [COORD_BITS-1:0] ax2_ff, ay2_ff;
   logic signed [DW-1:0]         d1x2_ff, d1y2_ff;
   // stage 3: cross products, sign folded into den
   logic signed [XW-1:0]         den_in, tn_in, sn_in;
   logic signed [XW-1:0]         den_ff, tn_ff, sn_ff;
   logic signed [COORD_BITS-1:0] ax3_ff, ay3_ff;
   logic signed [DW-1:0]         d1x3_ff, d1y3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         d1x_ff <= DW'(bx) - DW'(ax);
         d1y_ff <= DW'(by) - DW'(ay);
         d2x_ff <= DW'(ex) - DW'(sx);
         d2y_ff <= DW'(ey) - DW'(sy);
         cx_ff  <= DW'(sx) - DW'(ax);
         cy_ff  <= DW'(sy) - DW'(ay);
         ax1_ff <= ax;
         ay1_ff <= ay;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_den_a_ff <= PW'(d1x_ff) * PW'(d2y_ff);
         p_den_b_ff <= PW'(d1y_ff) * PW'(d2x_ff);
         p_tn_a_ff  <= PW'(cx_ff) * PW'(d2y_ff);
         p_tn_b_ff  <= PW'(cy_ff) * PW'(d2x_ff);
         p_sn_a_ff  <= PW'(cx_ff) * PW'(d1y_ff);
         p_sn_b_ff  <= PW'(cy_ff) * PW'(d1x_ff);
         ax2_ff     <= ax1_ff;
         ay2_ff     <= ay1_ff;
         d1x2_ff    <= d1x_ff;
         d1y2_ff    <= d1y_ff;
      end
   end

   always_comb begin
      logic signed [XW-1:0] raw_den, raw_tn, raw_sn;
      raw_den = XW'(p_den_a_ff) - XW'(p_den_b_ff);
      raw_tn  = XW'(p_tn_a_ff) - XW'(p_tn_b_ff);
      raw_sn  = XW'(p_sn_a_ff) - XW'(p_sn_b_ff);
      // flip all three so den is never negative
      if (raw_den[XW-1]) begin
         den_in = -raw_den;
         tn_in  = -raw_tn;
         sn_in  = -raw_sn;
      end else begin
         den_in = raw_den;
         tn_in  = raw_tn;
         sn_in  = raw_sn;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_ff  <= den_in;
         tn_ff   <= tn_in;
         sn_ff   <= sn_in;
         ax3_ff  <= ax2_ff;
         ay3_ff  <= ay2_ff;
         d1x3_ff <= d1x2_ff;
         d1y3_ff <= d1y2_ff;
      end
   end

   assign den     = den_ff;
   assign tn      = tn_ff;
   assign sn      = sn_ff;
   assign ax_out  = ax3_ff;
   assign ay_out  = ay3_ff;
   assign d1x_out = d1x3_ff;
   assign d1y_out = d1y3_ff;
endmodule
`default_nettype wire

FILE: sv/segi_lane.sv
// One coordinate lane: tn*|d| product, pipelined restoring divider (one quotient
// bit per stage), truncate-toward-zero fix-up and saturation. Depends on segi_pkg.
`default_nettype none
module segi_lane #(
   parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic        [2*COORD_BITS+1:0]      tn,
   input  wire logic        [2*COORD_BITS+1:0]      den,
   input  wire logic signed [COORD_BITS-1:0]        a,
   input  wire logic signed [COORD_BITS:0]          d,
   output logic signed [segi_pkg::OUT_BITS-1:0]     point
);
   localparam int C   = COORD_BITS;
   localparam int DW  = 2 * C + 2;            // remainder / divisor width
   localparam int QW  = C + FRAC_BITS;        // quotient width
   localparam int PW  = 3 * C + 2;            // tn * |d|
   localparam int RW  = C + FRAC_BITS + 2;    // fix-up arithmetic
   localparam int OW  = segi_pkg::OUT_BITS;
   localparam int SW  = (RW > OW) ? RW + 1 : OW + 1;
   localparam logic signed [SW-1:0] SatHi = SW'((64'sd1 <<< (OW - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] SatLo = -SatHi - SW'(1);

   logic [DW-1:0]         rem_ff  [0:QW];
   logic [QW-1:0]         lo_ff   [0:QW];
   logic [QW-1:0]         q_ff    [0:QW];
   logic [DW-1:0]         den_ff  [0:QW];
   logic signed [C-1:0]   a_ff    [0:QW];
   logic                  neg_ff  [0:QW];

   logic [C:0]            mag_full;
   logic [PW-1:0]         prod;

   assign mag_full = d[C] ? -d : d;
   assign prod     = PW'(tn) * PW'(mag_full[C-1:0]);

   // entry stage: the product's top bits already sit below den
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= prod[PW-1:C];
         lo_ff[0]  <= QW'(prod[C-1:0]) << FRAC_BITS;
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         a_ff[0]   <= a;
         neg_ff[0] <= d[C];
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_div
      logic [DW:0]   trial;
      logic          ge;
      logic [DW-1:0] rem_in;
      assign trial  = {rem_ff[k], lo_ff[k][QW-1]};
      assign ge     = trial >= {1'b0, den_ff[k]};
      assign rem_in = ge ? DW'(trial - {1'b0, den_ff[k]}) : DW'(trial);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            lo_ff[k+1]  <= lo_ff[k] << 1;
            q_ff[k+1]   <= {q_ff[k][QW-2:0], ge};
            den_ff[k+1] <= den_ff[k];
            a_ff[k+1]   <= a_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   // floor quotient plus inexact flag give truncation toward zero of a + t*d
   always_comb begin
      logic signed [RW-1:0] base, qv, qi, fl, cl, r;
      logic                 inx;
      logic signed [SW-1:0] rx;
      inx  = |rem_ff[QW];
      base = RW'(a_ff[QW]) <<< FRAC_BITS;
      qv   = signed'(RW'(q_ff[QW]));
      qi   = qv + RW'(inx);
      if (neg_ff[QW]) begin
         fl = -qi;
         cl = -qv;
      end else begin
         fl = qv;
         cl = qi;
      end
      r = base + fl;
      if (r[RW-1]) begin
         r = base + cl;
      end
      rx = SW'(r);
      if (rx > SatHi) begin
         rx = SatHi;
      end else if (rx < SatLo) begin
         rx = SatLo;
      end
      point = OW'(rx);
   end
endmodule
`default_nettype wire

FILE: sv/segment_intersection_core.sv
// Top level of the segment intersection core: handshake, valid/hit pipeline,
// miss substitution and output register. Depends on segi_pkg, segi_if, segi_cross, segi_lane.
//
//   channel | dir | payload                                          | moves on
//   req     | in  | wall_ax/ay, wall_bx/by, ray_start_x/y, ray_end_x/y | valid && ready
//   rsp     | out | hit, point_x, point_y (Q.FRAC_BITS, signed)        | valid && ready
//
// One item per cycle while the response is not stalled; the path runs through three front stages,
// the product stage, one divider stage per quotient bit and the output register.
// The quotient width of the divider sets the depth.
// Reset clears every valid bit; payload registers keep whatever they hold.
// A stalled response freezes the whole pipeline; req.ready drops with it.
`default_nettype none
module segment_intersection_core #(
   parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = segi_pkg::FRAC_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   segi_req_if.sink   req,
   segi_rsp_if.source rsp
);
   localparam int C    = COORD_BITS;
   localparam int XW   = 2 * C + 3;
   localparam int QW   = C + FRAC_BITS;
   localparam int NSTG = 4 + QW;              // stages ahead of the output register
   localparam int OW   = segi_pkg::OUT_BITS;
   localparam logic signed [OW-1:0] MissPt = OW'(-(64'sd1 <<< FRAC_BITS));

   logic                  en;
   logic [NSTG-1:0]       vld_ff;
   logic [QW:0]           hit_ff;
   logic                  hit_in;
   logic                  out_vld_ff;
   logic                  out_hit_ff;
   logic signed [OW-1:0]  out_x_ff, out_y_ff;

   logic signed [XW-1:0]  den, tn, sn;
   logic signed [C-1:0]   ax, ay;
   logic signed [C:0]     d1x, d1y;
   logic signed [OW-1:0]  px, py;

   // advance everything whenever the output slot is free or being drained
   assign en        = !out_vld_ff || rsp.ready;
   assign req.ready = en;

   segi_cross #(.COORD_BITS(C)) u_cross (
      .clock   (clock),
      .en      (en),
      .ax      (req.wall_ax),
      .ay      (req.wall_ay),
      .bx      (req.wall_bx),
      .by      (req.wall_by),
      .sx      (req.ray_start_x),
      .sy      (req.ray_start_y),
      .ex      (req.ray_end_x),
      .ey      (req.ray_end_y),
      .den     (den),
      .tn      (tn),
      .sn      (sn),
      .ax_out  (ax),
      .ay_out  (ay),
      .d1x_out (d1x),
      .d1y_out (d1y)
   );

   // exact strict test: 0 < tn < den and 0 < sn < den, den nonzero
   assign hit_in = (den != '0) && (tn > 0) && (tn < den) && (sn > 0) && (sn < den);

   segi_lane #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_lane_x (
      .clock (clock),
      .en    (en),
      .tn    (tn[XW-2:0]),
      .den   (den[XW-2:0]),
      .a     (ax),
      .d     (d1x),
      .point (px)
   );

   segi_lane #(.COORD_BITS(C), .FRAC_BITS(FRAC_BITS)) u_lane_y (
      .clock (clock),
      .en    (en),
      .tn    (tn[XW-2:0]),
      .den   (den[XW-2:0]),
      .a     (ay),
      .d     (d1y),
      .point (py)
   );

   // valid bits ride alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[NSTG-2:0], req.valid};
         out_vld_ff <= vld_ff[NSTG-1];
      end
   end

   // hit flag from the product stage onward; drop the point on a miss
   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff     <= {hit_ff[QW-1:0], hit_in};
         out_hit_ff <= hit_ff[QW];
         out_x_ff   <= hit_ff[QW] ? px : MissPt;
         out_y_ff   <= hit_ff[QW] ? py : MissPt;
      end
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.hit     = out_hit_ff;
   assign rsp.point_x = out_x_ff;
   assign rsp.point_y = out_y_ff;

   a_miss_point: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.hit) |-> (rsp.point_x == MissPt && rsp.point_y == MissPt))
      else $error("miss item carries a point other than -1.0");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> vld_ff[0])
      else $error("accepted item did not enter the pipeline");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> ($stable(vld_ff) && $stable(hit_ff)))
      else $error("pipeline moved during a response stall");
endmodule
`default_nettype wire

FILE: tb/sv/segment_intersection_core_tb.sv
// Self-checking testbench for segment_intersection_core: directed and random segment pairs,
// predicted in-bench and checked item by item. Depends on segi_pkg, segi_if and the core RTL.
`default_nettype none
module segment_intersection_core_tb;

   localparam int CB        = segi_pkg::COORD_BITS_DEF;
   localparam int FB        = segi_pkg::FRAC_BITS_DEF;
   localparam int OB        = segi_pkg::OUT_BITS;
   localparam int LATENCY   = 5 + CB + FB;
   localparam int N_RANDOM  = 530;
   localparam int LIMIT     = 400000;
   localparam int HOLD_AT   = 80;     // response count at which the long hold-off starts
   localparam int HOLD_LEN  = 300;    // cycles of the long hold-off, well beyond the depth
   localparam int QUIET_AT  = 50;     // no idling once this few items remain

   typedef struct packed {
      logic signed [CB-1:0] ax, ay, bx, by, sx, sy, ex, ey;
   } segment_pair_type;

   typedef struct packed {
      logic                    hit;
      logic signed [OB-1:0]    px;
      logic signed [OB-1:0]    py;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   segi_req_if #(.COORD_BITS(CB)) req_ch();
   segi_rsp_if                    rsp_ch();

   segment_intersection_core #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   segment_pair_type pairs_to_send[$];
   crossing_type     crossings_due[$];
   int               errors      = 0;
   int               cycles      = 0;
   int               rsp_seen    = 0;
   bit               quiet       = 1'b0;

   // ---------------------------------------------------------------------
   // Predictor: exact integer crossing test and wall point, truncated
   // toward zero, saturated to the output width.
   // ---------------------------------------------------------------------
   function automatic logic signed [OB-1:0] clamp_out(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (OB - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[OB-1:0];
   endfunction

   function automatic logic signed [OB-1:0] wall_coord(longint a, longint d,
                                                       longint tn, longint den);
      longint mag;
      longint prod;
      longint q;
      bit     inexact;
      longint fl;
      longint cl;
      longint base;
      longint r;
      mag     = (d < 0) ? -d : d;
      // tn < den < 2^34 and mag < 2^17, so the scaled product stays well inside 63 bits
      prod    = (tn * mag) <<< FB;
      q       = prod / den;
      inexact = (prod % den) != 0;
      if (d >= 0) begin
         fl = q;
         cl = q + (inexact ? 1 : 0);
      end else begin
         fl = -(q + (inexact ? 1 : 0));
         cl = -q;
      end
      base = a * (longint'(1) <<< FB);
      r    = base + fl;
      // below zero, round toward zero means taking the ceiling instead
      if (r < 0) r = base + cl;
      return clamp_out(r);
   endfunction

   function automatic crossing_type predict_crossing(segment_pair_type p);
      crossing_type c;
      longint       ax, ay, d1x, d1y, d2x, d2y, cx, cy, den, tn, sn;
      ax  = p.ax;
      ay  = p.ay;
      d1x = longint'(p.bx) - ax;
      d1y = longint'(p.by) - ay;
      d2x = longint'(p.ex) - longint'(p.sx);
      d2y = longint'(p.ey) - longint'(p.sy);
      cx  = longint'(p.sx) - ax;
      cy  = longint'(p.sy) - ay;
      den = d1x * d2y - d1y * d2x;
      tn  = cx * d2y - cy * d2x;
      sn  = cx * d1y - cy * d1x;
      // fold the sign of the denominator into the numerators
      if (den < 0) begin
         den = -den;
         tn  = -tn;
         sn  = -sn;
      end
      c.hit = (den != 0) && (tn > 0) && (tn < den) && (sn > 0) && (sn < den);
      if (c.hit) begin
         c.px = wall_coord(ax, d1x, tn, den);
         c.py = wall_coord(ay, d1y, tn, den);
      end else begin
         c.px = clamp_out(-(longint'(1) <<< FB));
         c.py = clamp_out(-(longint'(1) <<< FB));
      end
      return c;
   endfunction

   function automatic segment_pair_type mk(int ax, int ay, int bx, int by,
                                           int sx, int sy, int ex, int ey);
      segment_pair_type p;
      p.ax = ax[CB-1:0]; p.ay = ay[CB-1:0];
      p.bx = bx[CB-1:0]; p.by = by[CB-1:0];
      p.sx = sx[CB-1:0]; p.sy = sy[CB-1:0];
      p.ex = ex[CB-1:0]; p.ey = ey[CB-1:0];
      return p;
   endfunction

   // append one pair at the tail of the pending queue
   function automatic void queue_pair(segment_pair_type p);
      pairs_to_send.insert(pairs_to_send.size(), p);
   endfunction

   function automatic int rnd_coord(int span);
      return $urandom_range(2 * span) - span;
   endfunction

   // Random pair, half of them rays built to pass through the wall so that hits are common.
   function automatic segment_pair_type random_pair();
      int mode, span, ax, ay, bx, by, px, py, vx, vy, k, m;
      mode = $urandom_range(0, 9);
      span = ($urandom_range(0, 3) == 0) ? 20 : 8000;
      ax = rnd_coord(span); ay = rnd_coord(span);
      bx = rnd_coord(span); by = rnd_coord(span);
      vx = rnd_coord(span); vy = rnd_coord(span);
      case (mode)
         0, 1, 2, 3, 4: begin
            // ray crossing a point strictly inside the wall
            k  = $urandom_range(1, 15);
            px = ax + ((bx - ax) * k) / 16;
            py = ay + ((by - ay) * k) / 16;
            m  = $urandom_range(1, 4);
            return mk(ax, ay, bx, by, px + vx, py + vy, px - vx * m, py - vy * m);
         end
         5: begin
            // ray starting at an x and a y each taken from a wall end point, not always the same one
            return mk(ax, ay, bx, by, ($urandom_range(0, 1) != 0) ? ax : bx,
                      ($urandom_range(0, 1) != 0) ? ay : by, vx, vy);
         end
         6: begin
            // ray parallel to the wall
            k = $urandom_range(1, 3);
            return mk(ax, ay, bx, by, vx, vy, vx + (bx - ax) * k, vy + (by - ay) * k);
         end
         default: begin
            // full-range noise: every bit of every field toggles
            return mk($urandom(), $urandom(), $urandom(), $urandom(),
                      $urandom(), $urandom(), $urandom(), $urandom());
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      req_ch.valid       = 1'b0;
      req_ch.wall_ax     = '0;
      req_ch.wall_ay     = '0;
      req_ch.wall_bx     = '0;
      req_ch.wall_by     = '0;
      req_ch.ray_start_x = '0;
      req_ch.ray_start_y = '0;
      req_ch.ray_end_x   = '0;
      req_ch.ray_end_y   = '0;
      rsp_ch.ready       = 1'b0;

      // plain crossing, exact point
      queue_pair(mk(0, 0, 10, 0, 5, -5, 5, 5));
      // parallel, then collinear
      queue_pair(mk(0, 0, 10, 0, 0, 5, 10, 5));
      queue_pair(mk(0, 0, 10, 0, 2, 0, 8, 0));
      // ray starts on the wall, ray ends on the wall
      queue_pair(mk(0, 0, 10, 0, 5, 0, 5, 5));
      queue_pair(mk(0, 0, 10, 0, 5, -5, 5, 0));
      // ray touches the wall start, then the wall end
      queue_pair(mk(0, 0, 10, 0, 0, -5, 0, 5));
      queue_pair(mk(0, 0, 10, 0, 10, -5, 10, 5));
      // ray passes beyond the wall end
      queue_pair(mk(0, 0, 10, 0, 20, -5, 20, 5));
      // inexact fraction with a falling wall direction
      queue_pair(mk(10, 0, 0, 3, 3, -7, 4, 9));
      queue_pair(mk(-7, -3, -1, -9, -8, -8, 0, -2));
      // full-scale diagonals: the point lands just below zero
      queue_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      queue_pair(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
      queue_pair(mk(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768));
      // degenerate segments, the first two at the extremes
      queue_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      queue_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      queue_pair(mk(3, 4, 3, 4, 0, 0, 9, 9));
      // long segments across the full range, the first pair near-parallel
      queue_pair(mk(-32768, 0, 32767, 1, -32768, 1, 32767, -1));
      queue_pair(mk(-32768, -1, 32767, 32767, 32767, -32768, -32768, 32767));
      for (int i = 0; i < N_RANDOM; i++) queue_pair(random_pair());

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain: all items sent, all results back, then let the pipeline settle
      while (pairs_to_send.size() != 0 || crossings_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("segment_intersection_core_tb: PASS");
      end else begin
         $display("segment_intersection_core_tb: FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Driver: offer the head of the queue; idle only between items.
   // ---------------------------------------------------------------------
   int req_idle = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            crossings_due.insert(crossings_due.size(),
                                 predict_crossing(pairs_to_send.pop_front()));
            if (!quiet && $urandom_range(0, 5) == 0) req_idle = $urandom_range(1, 15);
         end
         if (pairs_to_send.size() < QUIET_AT) quiet = 1'b1;
         if (req_ch.valid && !req_ch.ready) begin
            // hold the item until it is taken
         end else if (req_idle > 0 && !quiet) begin
            req_idle--;
            req_ch.valid <= 1'b0;
         end else if (pairs_to_send.size() != 0) begin
            req_idle = 0;
            req_ch.valid       <= 1'b1;
            req_ch.wall_ax     <= pairs_to_send[0].ax;
            req_ch.wall_ay     <= pairs_to_send[0].ay;
            req_ch.wall_bx     <= pairs_to_send[0].bx;
            req_ch.wall_by     <= pairs_to_send[0].by;
            req_ch.ray_start_x <= pairs_to_send[0].sx;
            req_ch.ray_start_y <= pairs_to_send[0].sy;
            req_ch.ray_end_x   <= pairs_to_send[0].ex;
            req_ch.ray_end_y   <= pairs_to_send[0].ey;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result with the oldest prediction.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_seen++;
         if (crossings_due.size() == 0) begin
            $error("unexpected result: hit=%0b point_x=%0d point_y=%0d",
                   rsp_ch.hit, rsp_ch.point_x, rsp_ch.point_y);
            errors++;
         end else begin
            want = crossings_due.pop_front();
            if (rsp_ch.hit !== want.hit) begin
               $error("hit: expected %0b, got %0b", want.hit, rsp_ch.hit);
               errors++;
            end
            if (rsp_ch.point_x !== want.px) begin
               $error("point_x: expected %0d, got %0d", want.px, rsp_ch.point_x);
               errors++;
            end
            if (rsp_ch.point_y !== want.py) begin
               $error("point_y: expected %0d, got %0d", want.py, rsp_ch.point_y);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall the response side in bursts plus one long hold-off,
   // counted in cycles, that backs up the input.
   // ---------------------------------------------------------------------
   int  rsp_stall = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && rsp_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0 && !quiet) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_stall = 0;
         if (!quiet && $urandom_range(0, 7) == 0) rsp_stall = $urandom_range(1, 15);
         rsp_ch.ready <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("segment_intersection_core_tb: FAIL");
         $finish;
      end
   end
endmodule
`default_nettype wire
